[design/rtc_pkg.sv]
// Shared types, constants and calendar helper functions for the calendar clock.
`timescale 1ns / 1ps
`default_nettype none
package rtc_pkg;

  // Field limits
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  // Year table entry: leap flag in bit 3, weekday of 1 January in bits 2..0
  localparam logic [3:0] LEAP_FLAG = 4'h8;
  localparam logic [3:0] DOW_MASK  = 4'h7;

  // Item modes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Weekday after reset (Saturday)
  localparam logic [2:0] WEEKDAY_RESET = 3'd6;

  localparam logic [3:0] YEAR_HEAD [100] = '{
    4'he, 4'h1, 4'h2, 4'h3, 4'hc, 4'h6, 4'h0, 4'h1, 4'ha, 4'h4,
    4'h5, 4'h6, 4'h8, 4'h2, 4'h3, 4'h4, 4'hd, 4'h0, 4'h1, 4'h2,
    4'hb, 4'h5, 4'h6, 4'h0, 4'h9, 4'h3, 4'h4, 4'h5, 4'he, 4'h1,
    4'h2, 4'h3, 4'hc, 4'h6, 4'h0, 4'h1, 4'ha, 4'h4, 4'h5, 4'h6,
    4'h8, 4'h2, 4'h3, 4'h4, 4'hd, 4'h0, 4'h1, 4'h2, 4'hb, 4'h5,
    4'h6, 4'h0, 4'h9, 4'h3, 4'h4, 4'h5, 4'he, 4'h1, 4'h2, 4'h3,
    4'hc, 4'h6, 4'h0, 4'h1, 4'ha, 4'h4, 4'h5, 4'h6, 4'h8, 4'h2,
    4'h3, 4'h4, 4'hd, 4'h0, 4'h1, 4'h2, 4'hb, 4'h5, 4'h6, 4'h0,
    4'h9, 4'h3, 4'h4, 4'h5, 4'he, 4'h1, 4'h2, 4'h3, 4'hc, 4'h6,
    4'h0, 4'h1, 4'ha, 4'h4, 4'h5, 4'h6, 4'h8, 4'h2, 4'h3, 4'h4
  };

  // Calendar state
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } rtc_time_t;

  // One registered input item
  typedef struct packed {
    logic       mode;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rtc_cmd_t;

  // Event flags of one result
  typedef struct packed {
    logic minute_ev;
    logic day_ev;
  } rtc_events_t;

  // Length of a month; year 0..99, month 1..12
  function automatic logic [4:0] month_days(input logic [6:0] year, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the month, reduced modulo 7 (common year)
  function automatic logic [2:0] days_before_mod7(input logic [3:0] month);
    logic [2:0] r;
    case (month)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // x mod 7 for x below 64: quotient by reciprocal 37/256, exact in this range
  function automatic logic [2:0] mod7_6b(input logic [5:0] x);
    logic [11:0] prod;
    logic [3:0]  q;
    logic [6:0]  qx7;
    logic [6:0]  r;
    prod = 12'(x) * 12'd37;
    q    = prod[11:8];
    qx7  = 7'(q) * 7'd7;
    r    = 7'(x) - qx7;
    return r[2:0];
  endfunction

endpackage
`default_nettype wire

[design/rtc_if.sv]
// Valid/ready channel interfaces for calendar commands and calendar results.
`timescale 1ns / 1ps
`default_nettype none
interface rtc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [6:0] set_year;
  logic [3:0] set_month;
  logic [4:0] set_day;
  logic [4:0] set_hour;
  logic [5:0] set_minute;
  logic [5:0] set_second;

  modport source (
    output valid, mode, set_year, set_month, set_day, set_hour, set_minute, set_second,
    input  ready
  );
  modport sink (
    input  valid, mode, set_year, set_month, set_day, set_hour, set_minute, set_second,
    output ready
  );
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cur_year;
  logic [3:0] cur_month;
  logic [4:0] cur_day;
  logic [4:0] cur_hour;
  logic [5:0] cur_minute;
  logic [5:0] cur_second;
  logic [2:0] weekday;
  logic       minute_event;
  logic       day_event;

  modport source (
    output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
           weekday, minute_event, day_event,
    input  ready
  );
  modport sink (
    input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
           weekday, minute_event, day_event,
    output ready
  );
endinterface
`default_nettype wire

[design/rtc_weekday.sv]
// Day-of-week lookup from year table, month offset and day of month.
`timescale 1ns / 1ps
`default_nettype none
module rtc_weekday
  import rtc_pkg::*;
(
  input  wire logic [6:0] year,
  input  wire logic [3:0] month,
  input  wire logic [4:0] day,
  output logic      [2:0] weekday
);

  logic [3:0] head;
  logic       leap_adj;
  logic [5:0] sum;

  // Sum of reduced month offset, leap correction, day and Jan 1 weekday, minus one
  always_comb begin
    head     = YEAR_HEAD[year];
    leap_adj = ((head & LEAP_FLAG) != 4'h0) && (month > 4'd2);
    sum      = 6'(days_before_mod7(month)) + 6'(leap_adj) + 6'(day)
             + 6'(head & DOW_MASK) - 6'd1;
    weekday  = mod7_6b(sum);
  end

endmodule
`default_nettype wire

[design/rtc_update.sv]
// Next calendar state for one item: clamped write or one-second carry chain.
`timescale 1ns / 1ps
`default_nettype none
module rtc_update
  import rtc_pkg::*;
(
  input  wire rtc_time_t   cur,
  input  wire rtc_cmd_t    cmd,
  output rtc_time_t        nxt,
  output rtc_events_t      events
);

  rtc_time_t  wr;
  rtc_time_t  tk;
  logic [3:0] wr_month_lo;
  logic [4:0] wr_lim;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic [6:0] wd_year;
  logic [3:0] wd_month;
  logic [4:0] wd_day;
  logic [2:0] wd;

  // Write path: saturate every field of the command into its range
  always_comb begin
    wr         = cur;
    wr.year    = (cmd.year > YEAR_MAX) ? YEAR_MAX : cmd.year;
    wr_month_lo = (cmd.month == 4'd0) ? 4'd1 : cmd.month;
    wr.month   = (wr_month_lo > MONTH_MAX) ? MONTH_MAX : wr_month_lo;
    wr_lim     = month_days(wr.year, wr.month);
    if (cmd.day == 5'd0) begin
      wr.day = 5'd1;
    end else if (cmd.day > wr_lim) begin
      wr.day = wr_lim;
    end else begin
      wr.day = cmd.day;
    end
    wr.hour    = (cmd.hour > HOUR_MAX) ? HOUR_MAX : cmd.hour;
    wr.minute  = (cmd.minute > MINSEC_MAX) ? MINSEC_MAX : cmd.minute;
    wr.second  = (cmd.second > MINSEC_MAX) ? MINSEC_MAX : cmd.second;
  end

  // Tick path: carry chain seconds through years
  always_comb begin
    tk         = cur;
    sec_wrap   = (cur.second == MINSEC_MAX);
    min_wrap   = sec_wrap && (cur.minute == MINSEC_MAX);
    hour_wrap  = min_wrap && (cur.hour == HOUR_MAX);
    day_wrap   = hour_wrap && (cur.day == month_days(cur.year, cur.month));
    month_wrap = day_wrap && (cur.month == MONTH_MAX);

    tk.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
    if (sec_wrap) begin
      tk.minute = (cur.minute == MINSEC_MAX) ? 6'd0 : cur.minute + 6'd1;
    end
    if (min_wrap) begin
      tk.hour = (cur.hour == HOUR_MAX) ? 5'd0 : cur.hour + 5'd1;
    end
    if (hour_wrap) begin
      tk.day = day_wrap ? 5'd1 : cur.day + 5'd1;
    end
    if (day_wrap) begin
      tk.month = month_wrap ? 4'd1 : cur.month + 4'd1;
    end
    if (month_wrap) begin
      tk.year = (cur.year == YEAR_MAX) ? 7'd0 : cur.year + 7'd1;
    end
  end

  // One weekday lookup shared by both paths
  assign wd_year  = (cmd.mode == MODE_WRITE) ? wr.year  : tk.year;
  assign wd_month = (cmd.mode == MODE_WRITE) ? wr.month : tk.month;
  assign wd_day   = (cmd.mode == MODE_WRITE) ? wr.day   : tk.day;

  rtc_weekday u_weekday (
    .year    (wd_year),
    .month   (wd_month),
    .day     (wd_day),
    .weekday (wd)
  );

  // Select the path; weekday changes only on a write or a new day
  always_comb begin
    if (cmd.mode == MODE_WRITE) begin
      nxt              = wr;
      nxt.weekday      = wd;
      events.minute_ev = 1'b0;
      events.day_ev    = 1'b0;
    end else begin
      nxt              = tk;
      nxt.weekday      = hour_wrap ? wd : cur.weekday;
      events.minute_ev = sec_wrap;
      events.day_ev    = hour_wrap;
    end
  end

endmodule
`default_nettype wire

[design/rtc_calendar_tick.sv]
// Calendar clock top level: input register, update logic, state and result register.
// Path of an item: input register, then result register; the result register is
// loaded in the same cycle as the calendar state, when stage 1 advances.
// Throughput: one item per cycle while rsp.ready is high; the calendar update is a
// single pass of logic between the input register and the state and result registers.
// The input register accepts a new item while a finished result still waits.
// Reset (rst, synchronous): 1 January of year 0, 00:00:00, Saturday; both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module rtc_calendar_tick
  import rtc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  rtc_in_if.sink    req,
  rtc_out_if.source rsp
);

  logic        s1_valid;
  rtc_cmd_t    s1_cmd;
  rtc_time_t   cal;
  rtc_time_t   cal_next;
  rtc_events_t ev_next;
  logic        out_valid;
  rtc_time_t   out_time;
  rtc_events_t out_ev;
  logic        advance;

  // Stage 1 moves on when the result register is free or being emptied
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  rtc_update u_update (
    .cur    (cal),
    .cmd    (s1_cmd),
    .nxt    (cal_next),
    .events (ev_next)
  );

  // Control state and calendar
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      cal.year    <= 7'd0;
      cal.month   <= 4'd1;
      cal.day     <= 5'd1;
      cal.hour    <= 5'd0;
      cal.minute  <= 6'd0;
      cal.second  <= 6'd0;
      cal.weekday <= WEEKDAY_RESET;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        cal       <= cal_next;
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_cmd.mode   <= req.mode;
      s1_cmd.year   <= req.set_year;
      s1_cmd.month  <= req.set_month;
      s1_cmd.day    <= req.set_day;
      s1_cmd.hour   <= req.set_hour;
      s1_cmd.minute <= req.set_minute;
      s1_cmd.second <= req.set_second;
    end
    if (advance) begin
      out_time <= cal_next;
      out_ev   <= ev_next;
    end
  end

  // Result channel
  assign rsp.valid        = out_valid;
  assign rsp.cur_year     = out_time.year;
  assign rsp.cur_month    = out_time.month;
  assign rsp.cur_day      = out_time.day;
  assign rsp.cur_hour     = out_time.hour;
  assign rsp.cur_minute   = out_time.minute;
  assign rsp.cur_second   = out_time.second;
  assign rsp.weekday      = out_time.weekday;
  assign rsp.minute_event = out_ev.minute_ev;
  assign rsp.day_event    = out_ev.day_ev;

endmodule
`default_nettype wire
